### rtl/householder_reflector_unit_macros.svh
// Assertion macros for the householder reflector unit RTL.
`ifndef HOUSEHOLDER_REFLECTOR_UNIT_MACROS_SVH
`define HOUSEHOLDER_REFLECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HRU_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("householder reflector unit assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("householder reflector unit assertion failed");
`else
`define HRU_ASSERT_IMPLY(label, ante, cons)
`define HRU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/hru_pkg.sv
// Types and constants shared by the householder reflector unit modules.
package hru_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FRAC_BITS = 24;
    localparam int CFG_W     = 5;
    localparam int LEN_W     = 7;
    localparam int IDX_OUT_W = 4;
    localparam int MAG_W     = 40;
    localparam int F_W       = 40;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 57;
    localparam int SHIFT_W   = 6;
    localparam int PROD_W    = 66;

    localparam logic [CFG_W-1:0]           LEN_RESET = 5'd16;
    localparam logic signed [SAMPLE_W-1:0] ONE_Q     = 32'sh0100_0000;
    localparam logic [F_W-1:0]             F_LIMIT   = 40'h40_0000_0000;

    localparam logic MODE_BUILD     = 1'b0;
    localparam logic MODE_REFLECT   = 1'b1;
    localparam logic KIND_REFLECTOR = 1'b0;
    localparam logic KIND_REFLECTED = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] len;
    } job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NRD,
        ST_NMUL,
        ST_NACC,
        ST_SQRT,
        ST_ROOT,
        ST_ERD,
        ST_ESTART,
        ST_EWAIT,
        ST_EOUT,
        ST_BRD,
        ST_BMUL,
        ST_BACC,
        ST_FCALC,
        ST_RMUL,
        ST_ROUT
    } back_state_t;

endpackage

### rtl/hru_stream_ifs.sv
// Valid/ready channel interfaces for input samples and results.
interface hru_sample_if import hru_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output mode, output sample_value, input ready);
    modport sink (input valid, input mode, input sample_value, output ready);
endinterface

interface hru_result_if import hru_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       result_kind;
    logic [IDX_OUT_W-1:0]       element_index;
    logic signed [SAMPLE_W-1:0] result_value;
    logic                       last_element;

    modport source (output valid, output result_kind, output element_index,
                    output result_value, output last_element, input ready);
    modport sink (input valid, input result_kind, input element_index,
                  input result_value, input last_element, output ready);
endinterface

### rtl/householder_reflector_unit.sv
// Householder reflector unit. Samples are signed Q8.24 and are taken one per cycle
// into an element buffer; a mode 0 vector builds and emits the unit reflector v and
// keeps it, a mode 1 vector is reflected as y - 2(v.y)v and emitted, one result per
// element, last_element marking the end of the run. A build makes two norm passes on
// the shared multiplier, each followed by the two-bits-per-cycle square root (one more
// pass for each rescale of an oversized norm), then runs the one-bit-per-cycle divider
// once per element; a reflection makes one dot product pass and then a multiply and
// output step per element. Samples are held off from the last element of a vector
// until its final result sits in the output register, since the back end reads the
// element buffer throughout.
`include "householder_reflector_unit_macros.svh"
module householder_reflector_unit import hru_pkg::*;
#(
    parameter int MAX_LEN = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    hru_sample_if.sink       samples,
    hru_result_if.source     results,
    input  logic             cfg_write_enable,
    input  logic [CFG_W-1:0] cfg_write_data
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic                       job_push;
    job_t                       push_job;
    job_t                       head_job;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       job_pop;
    logic [IW-1:0]              rd_idx;
    logic signed [SAMPLE_W-1:0] rd_data;
    back_status_t               back_stat;

    // Intake and element buffer.
    hru_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .samples          (samples),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .job_push         (job_push),
        .job              (push_job),
        .job_full         (fifo_full),
        .back_done        (back_stat.done),
        .rd_idx           (rd_idx),
        .rd_data          (rd_data)
    );

    // Completed vectors waiting for the back end.
    hru_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (job_pop),
        .empty    (fifo_empty),
        .head_job (head_job)
    );

    // Arithmetic sequencer and result register.
    hru_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!fifo_empty),
        .job       (head_job),
        .job_pop   (job_pop),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .status    (back_stat),
        .results   (results)
    );

    // A vector is only issued to an idle back end, and finishes with nothing queued.
    `HRU_ASSERT_IMPLY(a_push_back_idle, job_push, !back_stat.busy)
    `HRU_ASSERT_IMPLY(a_done_queue_empty, back_stat.done, fifo_empty)
    `HRU_ASSERT_NEXT(a_done_then_idle, back_stat.done, !back_stat.busy)

endmodule

### rtl/hru_front.sv
// Front end: sample intake, length register, element buffer and job issue.
module hru_front import hru_pkg::*;
#(
    parameter int MAX_LEN = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    hru_sample_if.sink                 samples,
    input  logic                       cfg_write_enable,
    input  logic [CFG_W-1:0]           cfg_write_data,
    output logic                       job_push,
    output job_t                       job,
    input  logic                       job_full,
    input  logic                       back_done,
    input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_idx,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CFG_W-1:0]           vector_length_reg;
    logic [CW-1:0]              load_count_reg;
    logic                       load_mode_reg;
    logic                       pending_reg;
    logic signed [SAMPLE_W-1:0] buf_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic             accept;
    logic [LEN_W-1:0] cfg_len;
    logic [LEN_W-1:0] eff_len;
    logic [CW-1:0]    count_base;
    logic [CW-1:0]    count_after;
    logic             buf_we;
    logic             complete;

    // Clamp the programmed length into the usable range.
    always_comb
    begin
        cfg_len = LEN_W'(vector_length_reg);
        if (cfg_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (cfg_len > LEN_W'(MAX_LEN))
        begin
            eff_len = LEN_W'(MAX_LEN);
        end
        else
        begin
            eff_len = cfg_len;
        end
    end

    // A change of mode restarts the element count.
    assign accept      = samples.valid && samples.ready;
    assign count_base  = (samples.mode != load_mode_reg) ? '0 : load_count_reg;
    assign buf_we      = count_base < CW'(MAX_LEN);
    assign count_after = count_base + CW'(buf_we);
    assign complete    = LEN_W'(count_after) >= eff_len;

    // Hold off new samples while a vector is with the back end.
    assign samples.ready = !pending_reg && !job_full;
    assign job_push      = accept && complete;
    assign job.mode      = samples.mode;
    assign job.len       = eff_len;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= LEN_RESET;
            load_count_reg    <= '0;
            load_mode_reg     <= MODE_BUILD;
            pending_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                vector_length_reg <= cfg_write_data;
            end
            if (accept)
            begin
                load_mode_reg  <= samples.mode;
                load_count_reg <= complete ? '0 : count_after;
            end
            if (job_push)
            begin
                pending_reg <= 1'b1;
            end
            else if (back_done)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Element buffer with a registered read port for the back end.
    always_ff @(posedge clk)
    begin
        if (accept && buf_we)
        begin
            buf_mem[count_base[IW-1:0]] <= samples.sample_value;
        end
        rd_data_reg <= buf_mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/hru_job_fifo.sv
// Two-entry transaction queue between the front and back ends.
module hru_job_fifo import hru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign head_job = entry_reg[rd_ptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/hru_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module hru_sqrt import hru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]   rad_reg;
    logic [ROOT_W+3:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              take;

    // One restoring step.
    assign rem_sh = {rem_reg[ROOT_W+1:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = rem_sh >= trial;

    // Sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/hru_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module hru_div import hru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    dividend,
    input  logic [ROOT_W-1:0]   divisor,
    output logic                done,
    output logic [SAMPLE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [ROOT_W:0] rem_sh;
    logic            take;

    // One restoring step; the remainder stays below the divisor.
    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign take   = rem_sh >= {1'b0, div_reg};

    // Sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= take ? ROOT_W'(rem_sh - {1'b0, div_reg}) : rem_sh[ROOT_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_W-1:0];

endmodule

### rtl/hru_back.sv
// Back end: norm passes, reflector build, reflection and result output register.
module hru_back import hru_pkg::*;
#(
    parameter int MAX_LEN = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  job_t                       job,
    output logic                       job_pop,
    output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_idx,
    input  logic signed [SAMPLE_W-1:0] rd_data,
    output back_status_t               status,
    hru_result_if.source               results
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic [IW-1:0]      idx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               phase_u_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               degen_reg;
    logic               out_valid_reg;
    logic [MAX_LEN-1:0] store_valid_reg;

    logic [SQ_W-1:0]            sum_reg;
    logic [SAMPLE_W-1:0]        x0mag_reg;
    logic [MAG_W-1:0]           u0mag_reg;
    logic [ROOT_W-1:0]          nu_reg;
    logic                       neg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SQ_W-1:0]     beta_reg;
    logic signed [F_W-1:0]      f_reg;
    logic signed [SAMPLE_W-1:0] store_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] store_rd_reg;
    logic                       out_kind_reg;
    logic [IDX_OUT_W-1:0]       out_index_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic                       out_last_reg;

    logic                        is_last;
    logic                        out_free;
    logic [SAMPLE_W-1:0]         mag32;
    logic [MAG_W-1:0]            cur_mag;
    logic [MAG_W-1:0]            shifted;
    logic                        a_ovf;
    logic [SQ_W:0]               sq_sum;
    logic signed [F_W-1:0]       mul_a;
    logic signed [SAMPLE_W:0]    mul_b;
    logic signed [F_W+SAMPLE_W:0] product;
    logic [SQ_W:0]               bsum;
    logic signed [SQ_W-1:0]      beta_sat;
    logic [SQ_W-1:0]             beta_mag;
    logic [SQ_W-1:0]             beta_rnd;
    logic [F_W-1:0]              f_mag;
    logic signed [F_W-1:0]       f_calc;
    logic [PROD_W-1:0]           p_mag;
    logic [PROD_W-1:0]           p_rnd;
    logic [PROD_W-25:0]          d_mag;
    logic signed [PROD_W-22:0]   r_wide;
    logic signed [SAMPLE_W-1:0]  r_sat;
    logic [NUM_W-1:0]            dividend;
    logic [SAMPLE_W-1:0]         quotient;
    logic signed [SAMPLE_W-1:0]  v_value;
    logic [ROOT_W-1:0]           root;

    logic sqrt_start;
    logic sqrt_done;
    logic div_start;
    logic div_done;
    logic out_load;
    logic done;

    assign is_last  = LEN_W'(idx_reg) + LEN_W'(1) == len_reg;
    assign out_free = !out_valid_reg || results.ready;
    assign rd_idx   = idx_reg;

    // Element magnitude; entry zero of u carries the added norm.
    assign mag32   = rd_data[SAMPLE_W-1] ? SAMPLE_W'(-rd_data) : SAMPLE_W'(rd_data);
    assign cur_mag = (phase_u_reg && idx_reg == '0) ? u0mag_reg : MAG_W'(mag32);
    assign shifted = cur_mag >> shift_reg;
    assign a_ovf   = |shifted[MAG_W-1:ROOT_W];
    assign sq_sum  = {1'b0, sum_reg} + {1'b0, prod_reg[SQ_W-1:0]};

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_NMUL:
            begin
                mul_a = $signed(MAG_W'(shifted[ROOT_W-1:0]));
                mul_b = $signed({1'b0, shifted[ROOT_W-1:0]});
            end
            ST_BMUL:
            begin
                mul_a = F_W'(rd_data);
                mul_b = {store_rd_reg[SAMPLE_W-1], store_rd_reg};
            end
            ST_RMUL:
            begin
                mul_a = f_reg;
                mul_b = {store_rd_reg[SAMPLE_W-1], store_rd_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Saturating dot product accumulation.
    always_comb
    begin
        bsum = {beta_reg[SQ_W-1], beta_reg} + {prod_reg[SQ_W-1], prod_reg[SQ_W-1:0]};
        if (bsum[SQ_W] != bsum[SQ_W-1])
        begin
            beta_sat = bsum[SQ_W] ? {1'b1, {(SQ_W-1){1'b0}}} : {1'b0, {(SQ_W-1){1'b1}}};
        end
        else
        begin
            beta_sat = bsum[SQ_W-1:0];
        end
    end

    // Twice the dot product in Q16.24, rounded and clamped.
    always_comb
    begin
        beta_mag = beta_reg[SQ_W-1] ? SQ_W'(-beta_reg) : SQ_W'(beta_reg);
        beta_rnd = beta_mag + (SQ_W'(1) << (FRAC_BITS - 2));
        if (beta_rnd[SQ_W-1:FRAC_BITS-1] > (SQ_W-FRAC_BITS+1)'(F_LIMIT))
        begin
            f_mag = F_LIMIT;
        end
        else
        begin
            f_mag = beta_rnd[F_W+FRAC_BITS-2:FRAC_BITS-1];
        end
        f_calc = beta_reg[SQ_W-1] ? -$signed(f_mag) : $signed(f_mag);
    end

    // Reflected element: y minus the rounded correction, saturated.
    always_comb
    begin
        p_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        p_rnd  = p_mag + (PROD_W'(1) << (FRAC_BITS - 1));
        d_mag  = p_rnd[PROD_W-1:FRAC_BITS];
        if (prod_reg[PROD_W-1])
        begin
            r_wide = (PROD_W-21)'(rd_data) + $signed({3'b000, d_mag});
        end
        else
        begin
            r_wide = (PROD_W-21)'(rd_data) - $signed({3'b000, d_mag});
        end
        if (r_wide > $signed((PROD_W-21)'({1'b0, {(SAMPLE_W-1){1'b1}}})))
        begin
            r_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (r_wide < -$signed((PROD_W-21)'({1'b1, {(SAMPLE_W-1){1'b0}}})))
        begin
            r_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r_sat = r_wide[SAMPLE_W-1:0];
        end
    end

    // Rounded quotient for one reflector element.
    assign dividend = {1'b0, shifted[ROOT_W-1:0], {FRAC_BITS{1'b0}}}
                      + NUM_W'(nu_reg[ROOT_W-1:1]);
    always_comb
    begin
        if (degen_reg)
        begin
            v_value = (idx_reg == '0) ? ONE_Q : '0;
        end
        else
        begin
            v_value = neg_reg ? -$signed(quotient) : $signed(quotient);
        end
    end

    hru_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_sum[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    hru_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (nu_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job.mode == MODE_BUILD) ? ST_NRD : ST_BRD;
                end
            end
            ST_NRD:    state_next = ST_NMUL;
            ST_NMUL:   state_next = a_ovf ? ST_NRD : ST_NACC;
            ST_NACC:
            begin
                if (!sq_sum[SQ_W] && is_last)
                begin
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_NRD;
                end
            end
            ST_SQRT:   state_next = sqrt_done ? ST_ROOT : ST_SQRT;
            ST_ROOT:
            begin
                if (root == '0)
                begin
                    state_next = ST_EOUT;
                end
                else
                begin
                    state_next = phase_u_reg ? ST_ERD : ST_NRD;
                end
            end
            ST_ERD:    state_next = ST_ESTART;
            ST_ESTART: state_next = ST_EWAIT;
            ST_EWAIT:  state_next = div_done ? ST_EOUT : ST_EWAIT;
            ST_EOUT:
            begin
                if (out_free)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = degen_reg ? ST_EOUT : ST_ERD;
                    end
                end
            end
            ST_BRD:    state_next = ST_BMUL;
            ST_BMUL:   state_next = ST_BACC;
            ST_BACC:   state_next = is_last ? ST_FCALC : ST_BRD;
            ST_FCALC:  state_next = ST_RMUL;
            ST_RMUL:   state_next = ST_ROUT;
            ST_ROUT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_FCALC;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb
    begin
        job_pop    = (state_reg == ST_IDLE) && job_valid;
        sqrt_start = (state_reg == ST_NACC) && !sq_sum[SQ_W] && is_last;
        div_start  = state_reg == ST_ESTART;
        out_load   = ((state_reg == ST_EOUT) || (state_reg == ST_ROUT)) && out_free;
        done       = out_load && is_last;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            len_reg         <= '0;
            phase_u_reg     <= 1'b0;
            shift_reg       <= '0;
            degen_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            store_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        len_reg     <= job.len;
                        idx_reg     <= '0;
                        phase_u_reg <= 1'b0;
                        shift_reg   <= '0;
                        degen_reg   <= 1'b0;
                        if (job.mode == MODE_BUILD)
                        begin
                            store_valid_reg <= '0;
                        end
                    end
                end
                ST_NMUL:
                begin
                    if (a_ovf)
                    begin
                        shift_reg <= shift_reg + SHIFT_W'(1);
                        idx_reg   <= '0;
                    end
                end
                ST_NACC:
                begin
                    if (sq_sum[SQ_W])
                    begin
                        shift_reg <= shift_reg + SHIFT_W'(1);
                        idx_reg   <= '0;
                    end
                    else if (!is_last)
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_ROOT:
                begin
                    idx_reg <= '0;
                    if (root == '0)
                    begin
                        degen_reg <= 1'b1;
                    end
                    else if (!phase_u_reg)
                    begin
                        phase_u_reg <= 1'b1;
                        shift_reg   <= '0;
                    end
                end
                ST_EOUT:
                begin
                    if (out_load)
                    begin
                        store_valid_reg[idx_reg] <= 1'b1;
                        if (!is_last)
                        begin
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                end
                ST_BACC:
                begin
                    idx_reg <= is_last ? '0 : idx_reg + IW'(1);
                end
                ST_ROUT:
                begin
                    if (out_load && !is_last)
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        store_rd_reg <= store_valid_reg[idx_reg] ? store_mem[idx_reg] : '0;
        case (state_reg)
            ST_IDLE:
            begin
                sum_reg  <= '0;
                beta_reg <= '0;
            end
            ST_NMUL:
            begin
                if (a_ovf)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    prod_reg <= product[PROD_W-1:0];
                    if (!phase_u_reg && idx_reg == '0)
                    begin
                        x0mag_reg <= mag32;
                    end
                end
            end
            ST_NACC:
            begin
                sum_reg <= sq_sum[SQ_W] ? '0 : sq_sum[SQ_W-1:0];
            end
            ST_ROOT:
            begin
                if (!phase_u_reg)
                begin
                    u0mag_reg <= MAG_W'(x0mag_reg) + (MAG_W'(root) << shift_reg);
                    sum_reg   <= '0;
                end
                else
                begin
                    nu_reg <= root;
                end
            end
            ST_ESTART:
            begin
                neg_reg <= rd_data[SAMPLE_W-1];
            end
            ST_EOUT:
            begin
                if (out_load)
                begin
                    store_mem[idx_reg] <= v_value;
                    out_kind_reg       <= KIND_REFLECTOR;
                    out_index_reg      <= IDX_OUT_W'(idx_reg);
                    out_value_reg      <= v_value;
                    out_last_reg       <= is_last;
                end
            end
            ST_BMUL:
            begin
                prod_reg <= product[PROD_W-1:0];
            end
            ST_BACC:
            begin
                beta_reg <= beta_sat;
            end
            ST_FCALC:
            begin
                f_reg <= f_calc;
            end
            ST_RMUL:
            begin
                prod_reg <= product[PROD_W-1:0];
            end
            ST_ROUT:
            begin
                if (out_load)
                begin
                    out_kind_reg  <= KIND_REFLECTED;
                    out_index_reg <= IDX_OUT_W'(idx_reg);
                    out_value_reg <= r_sat;
                    out_last_reg  <= is_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid         = out_valid_reg;
    assign results.result_kind   = out_kind_reg;
    assign results.element_index = out_index_reg;
    assign results.result_value  = out_value_reg;
    assign results.last_element  = out_last_reg;

    assign status.busy = state_reg != ST_IDLE;
    assign status.done = done;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the householder reflector unit, with its own Q8.24 predictor.
module tb_top;
    import hru_pkg::*;

    localparam int  DEPTH       = 16;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  SETTLE      = 50;
    localparam int  LONG_HOLD   = 300;

    typedef struct {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] value;
    } sample_t;

    typedef struct {
        logic                       kind;
        logic [IDX_OUT_W-1:0]       index;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } element_t;

    typedef longint vec_t [DEPTH];

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_data;

    hru_sample_if samples_ch ();
    hru_result_if results_ch ();

    householder_reflector_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .samples          (samples_ch),
        .results          (results_ch),
        .cfg_write_enable (cfg_we),
        .cfg_write_data   (cfg_data)
    );

    // Predictor state: its own copy of the buffers, counters and length register.
    logic signed [SAMPLE_W-1:0] element_buf [DEPTH];
    logic signed [SAMPLE_W-1:0] reflector   [DEPTH];
    int unsigned                fill_count;
    logic                       fill_mode;
    logic [CFG_W-1:0]           length_reg;

    sample_t  samples_to_send [$];
    element_t elements_due    [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  sample_taken;
    bit  long_hold_req;
    int  hold_left;
    int  mismatch_count;
    int  cycle_count;

    // Unsigned magnitude of a signed 64-bit value.
    function automatic logic [63:0] magnitude(longint a);
        logic [63:0] ua;
        ua = a;
        return (a < 0) ? (64'd0 - ua) : ua;
    endfunction

    // Floored square root, one result bit per iteration.
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Norm over the components scaled down just enough for the squares to fit 64 bits.
    function automatic logic [63:0] scaled_norm(vec_t u, int n, output int shift);
        logic [63:0] sum;
        logic [63:0] a;
        logic [63:0] sq;
        bit          fits;
        for (int s = 0; s < 63; s++)
        begin
            sum  = 0;
            fits = 1;
            for (int i = 0; i < n; i++)
            begin
                a = magnitude(u[i]) >> s;
                if (a > 64'hFFFF_FFFF)
                begin
                    fits = 0;
                    break;
                end
                sq = a * a;
                if (sum > ~64'd0 - sq)
                begin
                    fits = 0;
                    break;
                end
                sum = sum + sq;
            end
            if (fits)
            begin
                shift = s;
                return floor_sqrt(sum);
            end
        end
        shift = 63;
        return 0;
    endfunction

    // Arithmetic right shift rounding half away from zero.
    function automatic longint round_shift(longint a, int k);
        logic [63:0] m;
        m = (magnitude(a) + (64'd1 << (k - 1))) >> k;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Forms the unit reflector from the first len buffered elements.
    function automatic void form_reflector(int len);
        vec_t        u;
        int          sx;
        int          su;
        logic [63:0] root;
        logic [63:0] nu;
        logic [63:0] a;
        logic [63:0] q;
        for (int i = 0; i < DEPTH; i++)
        begin
            reflector[i] = 0;
            u[i]         = 0;
        end
        for (int i = 0; i < len; i++) u[i] = element_buf[i];
        root = scaled_norm(u, len, sx);
        if (root == 0)
        begin
            reflector[0] = ONE_Q;
            return;
        end
        u[0] = (u[0] >= 0) ? u[0] + longint'(root << sx) : u[0] - longint'(root << sx);
        nu = scaled_norm(u, len, su);
        if (nu == 0)
        begin
            reflector[0] = ONE_Q;
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            a = magnitude(u[i]) >> su;
            q = ((a << FRAC_BITS) + nu / 2) / nu;
            reflector[i] = (u[i] < 0) ? -q[SAMPLE_W-1:0] : q[SAMPLE_W-1:0];
        end
    endfunction

    // Takes one accepted sample and queues the elements it is expected to produce.
    function automatic void predict_sample(sample_t s);
        int       len;
        longint   beta;
        longint   prod;
        longint   f;
        longint   d;
        longint   r;
        longint   top;
        element_t e;
        top = 64'sh7FFF_FFFF_FFFF_FFFF;
        len = (length_reg == 0) ? 1 : ((length_reg > DEPTH) ? DEPTH : int'(length_reg));
        if (s.mode != fill_mode)
        begin
            fill_mode  = s.mode;
            fill_count = 0;
        end
        if (fill_count < DEPTH)
        begin
            element_buf[fill_count] = s.value;
            fill_count++;
        end
        if (fill_count < len) return;
        fill_count = 0;
        if (s.mode == MODE_BUILD)
            form_reflector(len);
        else
        begin
            beta = 0;
            for (int i = 0; i < len; i++)
            begin
                prod = longint'(reflector[i]) * longint'(element_buf[i]);
                if (prod > 0 && beta > top - prod)
                    beta = top;
                else if (prod < 0 && beta < -top - 1 - prod)
                    beta = -top - 1;
                else
                    beta = beta + prod;
            end
            f = round_shift(beta, FRAC_BITS - 1);
            if (f > (64'sd1 <<< 38)) f = 64'sd1 <<< 38;
            if (f < -(64'sd1 <<< 38)) f = -(64'sd1 <<< 38);
        end
        for (int i = 0; i < len; i++)
        begin
            e.kind  = (s.mode == MODE_BUILD) ? KIND_REFLECTOR : KIND_REFLECTED;
            e.index = i[IDX_OUT_W-1:0];
            e.last  = (i + 1 == len);
            if (s.mode == MODE_BUILD)
                e.value = reflector[i];
            else
            begin
                d = round_shift(f * longint'(reflector[i]), FRAC_BITS);
                r = longint'(element_buf[i]) - d;
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                e.value = r[SAMPLE_W-1:0];
            end
            elements_due.push_back(e);
        end
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample driver: a new transaction is offered at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!samples_ch.valid || sample_taken)
            begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    samples_ch.valid        <= 1'b1;
                    samples_ch.mode         <= samples_to_send[0].mode;
                    samples_ch.sample_value <= samples_to_send[0].value;
                end
                else
                    samples_ch.valid <= 1'b0;
            end
            sample_taken = 0;
        end
    end

    // Accepted samples feed the predictor.
    always @(posedge clk)
    begin
        if (rst_n && samples_ch.valid && samples_ch.ready)
        begin
            predict_sample(samples_to_send.pop_front());
            sample_taken = 1;
        end
    end

    // Result receiver: random back-pressure plus the occasional long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor: each transaction is checked against the oldest expected element.
    always @(posedge clk)
    begin
        element_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (elements_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d index %0d value %h",
                             results_ch.result_kind, results_ch.element_index,
                             results_ch.result_value);
            end
            else
            begin
                want = elements_due.pop_front();
                if (results_ch.result_kind !== want.kind
                    || results_ch.element_index !== want.index
                    || results_ch.result_value !== want.value
                    || results_ch.last_element !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected kind %0d index %0d value %h last %0d,",
                                  " got kind %0d index %0d value %h last %0d"},
                                 want.kind, want.index, want.value, want.last,
                                 results_ch.result_kind, results_ch.element_index,
                                 results_ch.result_value, results_ch.last_element);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic push_sample(logic mode, logic signed [SAMPLE_W-1:0] value);
        sample_t s;
        s.mode  = mode;
        s.value = value;
        samples_to_send.push_back(s);
    endtask

    // Waits until every queued sample is taken and every expected element has arrived.
    task automatic wait_drained();
        while (samples_to_send.size() > 0 || samples_ch.valid || elements_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Length register write, done only while the block is idle.
    task automatic write_length(logic [CFG_W-1:0] len);
        @(negedge clk);
        cfg_we     = 1'b1;
        cfg_data   = len;
        length_reg = len;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endfunction

    function automatic logic [CFG_W-1:0] random_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return CFG_W'($urandom_range(17, 31));
        if (pick == 2) return CFG_W'(16);
        return CFG_W'($urandom_range(1, 6));
    endfunction

    // Random traffic: mostly a reflector build followed by reflections, some broken vectors.
    task automatic random_traffic(int count);
        int made;
        int len;
        made = 0;
        while (made < count)
        begin
            write_length(random_length());
            len = (length_reg == 0) ? 1 : ((length_reg > DEPTH) ? DEPTH : int'(length_reg));
            for (int v = 0; v < 3; v++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    for (int i = 0; i < $urandom_range(1, 3); i++)
                    begin
                        push_sample(1'($urandom_range(0, 1)), random_value());
                        made++;
                    end
                end
                for (int i = 0; i < len; i++)
                    push_sample((v == 0) ? MODE_BUILD : MODE_REFLECT, random_value());
                made += len;
            end
            wait_drained();
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_data                = '0;
        samples_ch.valid        = 1'b0;
        samples_ch.mode         = MODE_BUILD;
        samples_ch.sample_value = '0;
        results_ch.ready        = 1'b0;
        send_idle_pct           = 31;
        recv_idle_pct           = 56;
        mismatch_count          = 0;
        cycle_count             = 0;
        hold_left               = 0;
        long_hold_req           = 0;
        sample_taken            = 0;
        fill_count              = 0;
        fill_mode               = MODE_BUILD;
        length_reg              = LEN_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            element_buf[i] = 0;
            reflector[i]   = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Length zero behaves as one; the reset reflector leaves y untouched.
        write_length(0);
        push_sample(MODE_REFLECT, 32'sh7FFF_FFFF);
        push_sample(MODE_BUILD, 0);
        wait_drained();

        // Extreme elements with a negative leading element, then a reflection.
        write_length(4);
        push_sample(MODE_BUILD, 32'sh8000_0000);
        push_sample(MODE_BUILD, 32'sh7FFF_FFFF);
        push_sample(MODE_BUILD, 1);
        push_sample(MODE_BUILD, -1);
        push_sample(MODE_REFLECT, 32'sh7FFF_FFFF);
        push_sample(MODE_REFLECT, 32'sh8000_0000);
        push_sample(MODE_REFLECT, 0);
        push_sample(MODE_REFLECT, ONE_Q);
        // An all-zero x gives the first unit vector.
        for (int i = 0; i < 4; i++) push_sample(MODE_BUILD, 0);
        // A mode change part-way through restarts the count.
        push_sample(MODE_BUILD, ONE_Q);
        push_sample(MODE_BUILD, -ONE_Q);
        for (int i = 0; i < 4; i++) push_sample(MODE_REFLECT, ONE_Q * (i + 1));
        // Part of a vector, then a shorter length completes it at the next element.
        for (int i = 0; i < 3; i++) push_sample(MODE_BUILD, ONE_Q + i);
        wait_drained();
        write_length(2);
        push_sample(MODE_BUILD, 32'sh0080_0000);
        push_sample(MODE_REFLECT, 32'sh0100_0000);
        push_sample(MODE_REFLECT, -32'sh0300_0000);
        wait_drained();

        // The receiver holds off while full-length vectors keep arriving.
        write_length(16);
        long_hold_req = 1;
        for (int i = 0; i < 16; i++) push_sample(MODE_BUILD, random_value());
        for (int i = 0; i < 16; i++) push_sample(MODE_REFLECT, random_value());
        wait_drained();
        write_length(31);
        for (int i = 0; i < 16; i++) push_sample(MODE_REFLECT, random_value());
        wait_drained();

        random_traffic(25);
        send_idle_pct = 56;
        recv_idle_pct = 31;
        random_traffic(25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(25);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && elements_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/hru_pkg.sv
rtl/hru_stream_ifs.sv
rtl/hru_front.sv
rtl/hru_job_fifo.sv
rtl/hru_sqrt.sv
rtl/hru_div.sv
rtl/hru_back.sv
rtl/householder_reflector_unit.sv
sim/tb_top.sv
